### sv/sdi_pkg.sv
// -----------------------------------------------------------------------------
// SD card SPI init sequencer package
// Shared types and constants for the sequencer and its step logic.
// -----------------------------------------------------------------------------
package sdi_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [1:0] CFG_BLOCK_LENGTH = 2'd0;
  localparam logic [1:0] CFG_READY_TMO    = 2'd1;
  localparam logic [1:0] CFG_INIT_TMO     = 2'd2;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_WAKE     = 4'd1;
  localparam logic [3:0] PH_CMD0     = 4'd2;
  localparam logic [3:0] PH_CMD8     = 4'd3;
  localparam logic [3:0] PH_R7       = 4'd4;
  localparam logic [3:0] PH_HCS_LOOP = 4'd5;
  localparam logic [3:0] PH_CMD58    = 4'd6;
  localparam logic [3:0] PH_OCR      = 4'd7;
  localparam logic [3:0] PH_PROBE    = 4'd8;
  localparam logic [3:0] PH_OP_LOOP  = 4'd9;
  localparam logic [3:0] PH_CMD16    = 4'd10;
  localparam logic [3:0] PH_FINAL    = 4'd11;
  localparam logic [3:0] PH_DONE     = 4'd12;

  localparam logic [2:0] LK_NONE     = 3'd0;
  localparam logic [2:0] LK_DESEL    = 3'd1;
  localparam logic [2:0] LK_SEL      = 3'd2;
  localparam logic [2:0] LK_READY    = 3'd3;
  localparam logic [2:0] LK_FRAME    = 3'd4;
  localparam logic [2:0] LK_RESP     = 3'd5;
  localparam logic [2:0] LK_FAILDESEL = 3'd6;

  localparam logic [2:0] TYPE_NONE = 3'd0;
  localparam logic [2:0] TYPE_MMC  = 3'd1;
  localparam logic [2:0] TYPE_SDV1 = 3'd2;
  localparam logic [2:0] TYPE_SDV2 = 3'd3;
  localparam logic [2:0] TYPE_SDHC = 3'd4;

  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_SEND_OP  = 6'd1;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_APP_OP   = 6'd41;
  localparam logic [5:0] CMD_APP      = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [7:0] CRC_CMD0  = 8'h95;
  localparam logic [7:0] CRC_CMD8  = 8'h87;
  localparam logic [7:0] CRC_OTHER = 8'h01;
  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

  // Sequencer state carried between byte transactions.
  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  link;
    logic [3:0]  byte_index;
    logic [3:0]  poll_count;
    logic [15:0] elapsed_ms;
    logic [15:0] ready_ms;
    logic [5:0]  cmd_code;
    logic [31:0] cmd_arg;
    logic        app_pending;
    logic [7:0]  resp_byte;
    logic [31:0] cond_bytes;
    logic [2:0]  trial_type;
    logic [2:0]  det_type;
    logic        uninit;
    logic        legacy_op;
  } seq_state_t;

  // One result transaction.
  typedef struct packed {
    logic       valid;
    logic [7:0] tx_byte;
    logic       cs_low;
    logic       finished;
    logic [2:0] card_type;
    logic       not_init;
  } seq_result_t;

endpackage

### sv/sdi_step.sv
// -----------------------------------------------------------------------------
// SD card SPI init step logic
// Computes the next sequencer state and the result of one input transaction.
// -----------------------------------------------------------------------------
module sdi_step #(
  parameter int unsigned RESPONSE_POLL_BYTES = 10,
  parameter int unsigned WAKE_DUMMY_BYTES    = 10
) (
  input  sdi_pkg::seq_state_t  state_i,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [12:0]          block_length_i,
  input  logic [15:0]          ready_tmo_i,
  input  logic [15:0]          init_tmo_i,
  output sdi_pkg::seq_state_t  state_o,
  output sdi_pkg::seq_result_t result_o
);
  import sdi_pkg::*;

  localparam logic [3:0] PollMax = 4'(RESPONSE_POLL_BYTES);
  localparam logic [3:0] WakeMax = 4'(WAKE_DUMMY_BYTES);

  seq_state_t s;
  logic       in_time;
  logic [5:0] fr_code;
  logic [31:0] fr_arg;
  logic [7:0] fr_byte;
  logic [31:0] cond_next;
  logic       ready_ok;
  logic       ready_wait;
  logic       resp_done;
  logic [7:0] resp_val;
  logic       use_stage;
  logic       use_restart;
  logic       stage_finish;
  logic [2:0] stage_type;

  // Frame byte for the current index.
  always_comb begin
    fr_code = state_i.app_pending ? CMD_APP : state_i.cmd_code;
    fr_arg  = state_i.app_pending ? 32'd0 : state_i.cmd_arg;
    unique case (state_i.link == LK_READY ? 4'd0 : state_i.byte_index)
      4'd0:    fr_byte = {2'b01, fr_code};
      4'd1:    fr_byte = fr_arg[31:24];
      4'd2:    fr_byte = fr_arg[23:16];
      4'd3:    fr_byte = fr_arg[15:8];
      4'd4:    fr_byte = fr_arg[7:0];
      default: begin
        if (fr_code == CMD_GO_IDLE)      fr_byte = CRC_CMD0;
        else if (fr_code == CMD_IF_COND) fr_byte = CRC_CMD8;
        else                             fr_byte = CRC_OTHER;
      end
    endcase
  end

  assign in_time    = state_i.elapsed_ms < init_tmo_i;
  assign cond_next  = {state_i.cond_bytes[23:0], rx_byte_i};
  assign ready_ok   = (rx_byte_i == 8'hFF) && (state_i.ready_ms <= ready_tmo_i);
  assign ready_wait = (rx_byte_i != 8'hFF) && (state_i.ready_ms < ready_tmo_i);

  // Main transition.
  always_comb begin
    s = state_i;
    result_o = '0;
    result_o.card_type = state_i.det_type;
    result_o.not_init  = state_i.uninit;
    resp_done = 1'b0;
    resp_val  = 8'hFF;
    use_stage = 1'b0;
    use_restart = 1'b0;
    stage_finish = 1'b0;
    stage_type = TYPE_NONE;

    unique case (operation_i)
      OP_TICK: begin
        if (s.elapsed_ms != 16'hFFFF) s.elapsed_ms = s.elapsed_ms + 16'd1;
        if (s.ready_ms != 16'hFFFF) s.ready_ms = s.ready_ms + 16'd1;
      end
      OP_START: begin
        s.phase = PH_WAKE;
        s.link = LK_NONE;
        s.byte_index = 4'd1;
        s.poll_count = 4'd0;
        s.elapsed_ms = '0;
        s.ready_ms = '0;
        s.app_pending = 1'b0;
        s.cond_bytes = '0;
        s.trial_type = TYPE_NONE;
        s.legacy_op = 1'b0;
        result_o.valid = 1'b1;
        result_o.tx_byte = 8'hFF;
      end
      OP_BYTE: begin
        if (state_i.phase != PH_IDLE && state_i.phase != PH_DONE) begin
          result_o.valid = 1'b1;
          result_o.tx_byte = 8'hFF;
          priority case (1'b1)
            state_i.phase == PH_WAKE: begin
              if (state_i.byte_index < WakeMax) begin
                s.byte_index = state_i.byte_index + 4'd1;
              end else begin
                s.phase = PH_CMD0;
                s.cmd_code = CMD_GO_IDLE;
                s.cmd_arg = '0;
                s.app_pending = 1'b0;
                s.link = LK_DESEL;
              end
            end
            state_i.phase == PH_R7 || state_i.phase == PH_OCR: begin
              s.cond_bytes = cond_next;
              s.byte_index = state_i.byte_index + 4'd1;
              if (s.byte_index < 4'd4) begin
                result_o.cs_low = 1'b1;
              end else if (state_i.phase == PH_OCR) begin
                stage_finish = 1'b1;
                stage_type = cond_next[30] ? TYPE_SDHC : TYPE_SDV2;
              end else if (cond_next[15:0] == 16'h01AA) begin
                // The loop timer restarts at zero, so only a zero limit ends it at once.
                s.elapsed_ms = '0;
                s.phase = PH_HCS_LOOP;
                if (init_tmo_i != 16'd0) begin
                  s.cmd_code = CMD_APP_OP; s.cmd_arg = ARG_HCS;
                  s.app_pending = 1'b1; s.link = LK_DESEL;
                end else begin
                  stage_finish = 1'b1;
                end
              end else begin
                stage_finish = 1'b1;
              end
            end
            state_i.phase == PH_FINAL: begin
              s.det_type = state_i.trial_type;
              s.uninit = (state_i.trial_type == TYPE_NONE);
              s.phase = PH_DONE;
              result_o.tx_byte = 8'h00;
              result_o.finished = 1'b1;
              result_o.card_type = state_i.trial_type;
              result_o.not_init = (state_i.trial_type == TYPE_NONE);
            end
            default: begin
              unique case (state_i.link)
                LK_DESEL: begin
                  s.link = LK_SEL;
                  result_o.cs_low = 1'b1;
                end
                LK_SEL: begin
                  s.link = LK_READY;
                  s.ready_ms = '0;
                  result_o.cs_low = 1'b1;
                end
                LK_READY: begin
                  if (ready_ok) begin
                    s.link = LK_FRAME;
                    s.byte_index = 4'd1;
                    result_o.tx_byte = fr_byte;
                    result_o.cs_low = 1'b1;
                  end else if (ready_wait) begin
                    result_o.cs_low = 1'b1;
                  end else begin
                    s.link = LK_FAILDESEL;
                  end
                end
                LK_FRAME: begin
                  result_o.cs_low = 1'b1;
                  if (state_i.byte_index < 4'd6) begin
                    result_o.tx_byte = fr_byte;
                    s.byte_index = state_i.byte_index + 4'd1;
                  end else begin
                    s.link = LK_RESP;
                    s.poll_count = 4'd1;
                  end
                end
                LK_RESP: begin
                  if (rx_byte_i[7] && state_i.poll_count < PollMax) begin
                    s.poll_count = state_i.poll_count + 4'd1;
                    result_o.cs_low = 1'b1;
                  end else begin
                    resp_done = 1'b1;
                    resp_val = rx_byte_i;
                  end
                end
                LK_FAILDESEL: begin
                  resp_done = 1'b1;
                end
                default: stage_finish = 1'b1;
              endcase
            end
          endcase

          // Command response handling.
          if (resp_done) begin
            s.resp_byte = resp_val;
            if (state_i.app_pending && resp_val <= 8'd1) begin
              s.app_pending = 1'b0;
              use_restart = 1'b1;
            end else begin
              use_stage = 1'b1;
            end
          end
          if (use_restart) begin
            s.link = LK_DESEL;
          end
          if (use_stage) begin
            s.link = LK_NONE;
            unique case (state_i.phase)
              PH_CMD0: begin
                if (resp_val == 8'd1) begin
                  s.phase = PH_CMD8; s.cmd_code = CMD_IF_COND; s.cmd_arg = ARG_IF_COND;
                  s.app_pending = 1'b0; s.link = LK_DESEL;
                end else stage_finish = 1'b1;
              end
              PH_CMD8: begin
                if (resp_val == 8'd1) begin
                  s.phase = PH_R7; s.byte_index = 4'd0; s.cond_bytes = '0;
                  result_o.cs_low = 1'b1;
                end else begin
                  s.phase = PH_PROBE; s.cmd_code = CMD_APP_OP; s.cmd_arg = '0;
                  s.app_pending = 1'b1; s.link = LK_DESEL;
                end
              end
              PH_HCS_LOOP: begin
                if (resp_val != 8'd0) begin
                  if (in_time) begin
                    s.cmd_code = CMD_APP_OP; s.cmd_arg = ARG_HCS;
                    s.app_pending = 1'b1; s.link = LK_DESEL;
                  end else stage_finish = 1'b1;
                end else if (in_time) begin
                  s.phase = PH_CMD58; s.cmd_code = CMD_READ_OCR; s.cmd_arg = '0;
                  s.app_pending = 1'b0; s.link = LK_DESEL;
                end else stage_finish = 1'b1;
              end
              PH_CMD58: begin
                if (resp_val == 8'd0) begin
                  s.phase = PH_OCR; s.byte_index = 4'd0; s.cond_bytes = '0;
                  result_o.cs_low = 1'b1;
                end else stage_finish = 1'b1;
              end
              PH_PROBE: begin
                // Probe decides SDv1 versus MMC; the timer restarts at zero.
                s.trial_type = (resp_val <= 8'd1) ? TYPE_SDV1 : TYPE_MMC;
                s.legacy_op = (resp_val > 8'd1);
                s.elapsed_ms = '0;
                s.phase = PH_OP_LOOP;
                if (init_tmo_i != 16'd0) begin
                  s.cmd_code = s.legacy_op ? CMD_SEND_OP : CMD_APP_OP;
                  s.cmd_arg = '0; s.app_pending = !s.legacy_op; s.link = LK_DESEL;
                end else begin
                  stage_finish = 1'b1;
                end
              end
              PH_OP_LOOP: begin
                if (resp_val != 8'd0) begin
                  if (in_time) begin
                    s.cmd_code = state_i.legacy_op ? CMD_SEND_OP : CMD_APP_OP;
                    s.cmd_arg = '0; s.app_pending = !state_i.legacy_op;
                    s.link = LK_DESEL;
                  end else stage_finish = 1'b1;
                end else if (in_time) begin
                  s.phase = PH_CMD16; s.cmd_code = CMD_BLOCKLEN;
                  s.cmd_arg = {19'd0, block_length_i};
                  s.app_pending = 1'b0; s.link = LK_DESEL;
                end else stage_finish = 1'b1;
              end
              PH_CMD16: begin
                stage_finish = 1'b1;
                stage_type = (resp_val == 8'd0) ? state_i.trial_type : TYPE_NONE;
              end
              default: stage_finish = 1'b1;
            endcase
          end

          // Leave for the final deselect byte.
          if (stage_finish) begin
            s.trial_type = stage_type;
            s.phase = PH_FINAL;
            s.link = LK_NONE;
            result_o.tx_byte = 8'hFF;
            result_o.cs_low = 1'b0;
          end
        end
      end
      default: ;
    endcase
    state_o = s;
  end

endmodule

### sv/sd_spi_card_init_sequencer_top.sv
// -----------------------------------------------------------------------------
// SD card SPI-mode init sequencer, top level
// Drives the byte-level bring-up of an SD or MMC card over SPI.
// -----------------------------------------------------------------------------
// Usage: the input channel carries an operation (start, byte received,
// millisecond tick) and the byte last clocked in from the card. Each start
// and each byte received while a sequence runs yields one result transaction
// with the next byte to exchange, the chip-select level, and on the last one
// the finished flag with the detected card type. Ticks and stray bytes give
// no result.
// An accepted transaction is worked out in the cycle of acceptance and its
// result sits in the output register on the next cycle.
// Throughput is one transaction per cycle while the result register drains,
// set by the single state update. Input is taken only if that register is
// empty or being drained in the same cycle; while the receiver stalls on a
// held result, it holds, and ticks and stray bytes wait as well.
// Reset puts the block idle with card type none, not initialized, and the
// registers at block length 512, ready timeout 500 ms, init timeout 1000 ms.
// -----------------------------------------------------------------------------
module sd_spi_card_init_sequencer_top #(
  parameter int unsigned RESPONSE_POLL_BYTES = 10,
  parameter int unsigned WAKE_DUMMY_BYTES    = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        chip_select_low_o,
  output logic        finished_o,
  output logic [2:0]  card_type_o,
  output logic        not_initialized_o
);
  import sdi_pkg::*;

  // Sequencer state after reset: idle, response all ones, not initialized.
  localparam seq_state_t StateReset = '{resp_byte: 8'hFF, uninit: 1'b1, default: '0};

  seq_state_t  state_q, state_d;
  seq_result_t res_q, res_c;
  logic [12:0] block_length_q;
  logic [15:0] ready_tmo_q, init_tmo_q;
  logic        out_free;
  logic        accept;

  sdi_step #(
    .RESPONSE_POLL_BYTES(RESPONSE_POLL_BYTES),
    .WAKE_DUMMY_BYTES   (WAKE_DUMMY_BYTES)
  ) u_step (
    .state_i       (state_q),
    .operation_i   (operation_i),
    .rx_byte_i     (rx_byte_i),
    .block_length_i(block_length_q),
    .ready_tmo_i   (ready_tmo_q),
    .init_tmo_i    (init_tmo_q),
    .state_o       (state_d),
    .result_o      (res_c)
  );

  // Stall the input only when a result would collide with a held one.
  assign out_free   = !res_q.valid || !out_stall_i;
  assign in_stall_o = !out_free;
  assign accept     = in_valid_i && out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= 13'd512;
      ready_tmo_q <= 16'd500;
      init_tmo_q <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLOCK_LENGTH: block_length_q <= cfg_data_i[12:0];
        CFG_READY_TMO:    ready_tmo_q <= cfg_data_i;
        CFG_INIT_TMO:     init_tmo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
      res_q <= '0;
    end else begin
      if (accept) state_q <= state_d;
      if (accept) res_q <= res_c;
      else if (!out_stall_i) res_q.valid <= 1'b0;
    end
  end

  assign out_valid_o       = res_q.valid;
  assign tx_byte_o         = res_q.tx_byte;
  assign chip_select_low_o = res_q.cs_low;
  assign finished_o        = res_q.finished;
  assign card_type_o       = res_q.card_type;
  assign not_initialized_o = res_q.not_init;

endmodule

### sv/sdi_checker.sv
// -----------------------------------------------------------------------------
// SD card SPI init sequencer checker
// Port-level assertions, bound to the top level.
// -----------------------------------------------------------------------------
module sdi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] tx_byte_o,
  input logic       chip_select_low_o,
  input logic       finished_o,
  input logic [2:0] card_type_o,
  input logic       not_initialized_o
);

  // A stalled result transaction holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o))
    else $error("result changed under stall");

  // The input stalls only while a result is held back.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without cause");

  // A finished transaction sends nothing and releases the card.
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> tx_byte_o == 8'h00 && !chip_select_low_o)
    else $error("finished transaction drives the link");

  // The not-initialized flag agrees with card type none.
  a_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> not_initialized_o == (card_type_o == 3'd0))
    else $error("card type and flag disagree");

endmodule

bind sd_spi_card_init_sequencer_top sdi_checker u_sdi_checker (.*);

### verif/sd_spi_card_init_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// SD card SPI init sequencer checker
// Watches the configuration port and both channels of the sequencer, predicts
// every result transaction from the accepted input transactions, and compares
// each accepted result field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module sd_spi_card_init_checker #(
  parameter int unsigned POLL_BYTES  = 10,
  parameter int unsigned DUMMY_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        chip_select_low_i,
  input  logic        finished_i,
  input  logic [2:0]  card_type_i,
  input  logic        not_initialized_i,
  output int          fail_count_o,
  output int          pending_o
);
  import sdi_pkg::*;

  typedef struct packed {
    logic [7:0] tx;
    logic       cs;
    logic       fin;
    logic [2:0] ctype;
    logic       ninit;
  } card_result_t;

  // Register mirror.
  logic [12:0] blk_len;
  logic [15:0] rdy_tmo;
  logic [15:0] init_tmo;

  // Predicted sequencer state.
  logic [3:0]  ph;
  logic [2:0]  lk;
  logic [3:0]  bidx;
  logic [3:0]  pcnt;
  logic [15:0] el_ms;
  logic [15:0] rd_ms;
  logic [5:0]  code;
  logic [31:0] arg;
  logic        app;
  logic [7:0]  resp;
  logic [31:0] cond;
  logic [2:0]  trial;
  logic [2:0]  det;
  logic        uninit;
  logic        legacy;

  card_result_t expected_results[$];
  int mismatches;

  function automatic card_result_t mk(logic [7:0] tx, logic cs, logic fin);
    mk = '{tx, cs, fin, det, uninit};
  endfunction

  function automatic card_result_t start_link();
    lk = LK_DESEL;
    return mk(8'hFF, 1'b0, 1'b0);
  endfunction

  function automatic card_result_t issue_cmd(logic [5:0] c, logic [31:0] a, logic ap);
    code = c;
    arg  = a;
    app  = ap;
    return start_link();
  endfunction

  function automatic card_result_t wrap_up(logic [2:0] ty);
    trial = ty;
    ph    = PH_FINAL;
    lk    = LK_NONE;
    return mk(8'hFF, 1'b0, 1'b0);
  endfunction

  function automatic card_result_t read_cond(logic [3:0] nph);
    ph   = nph;
    lk   = LK_NONE;
    bidx = '0;
    cond = '0;
    return mk(8'hFF, 1'b1, 1'b0);
  endfunction

  function automatic card_result_t hcs_next();
    if (el_ms < init_tmo) return issue_cmd(CMD_APP_OP, ARG_HCS, 1'b1);
    return wrap_up(TYPE_NONE);
  endfunction

  function automatic card_result_t op_next();
    if (el_ms < init_tmo) begin
      if (legacy) return issue_cmd(CMD_SEND_OP, 32'd0, 1'b0);
      return issue_cmd(CMD_APP_OP, 32'd0, 1'b1);
    end
    return wrap_up(TYPE_NONE);
  endfunction

  // Decision taken once a command has its response.
  function automatic card_result_t stage_done(logic [7:0] r);
    logic in_time;
    in_time = el_ms < init_tmo;
    lk = LK_NONE;
    case (ph)
      PH_CMD0: begin
        if (r == 8'd1) begin
          ph = PH_CMD8;
          return issue_cmd(CMD_IF_COND, ARG_IF_COND, 1'b0);
        end
        return wrap_up(TYPE_NONE);
      end
      PH_CMD8: begin
        if (r == 8'd1) return read_cond(PH_R7);
        ph = PH_PROBE;
        return issue_cmd(CMD_APP_OP, 32'd0, 1'b1);
      end
      PH_HCS_LOOP: begin
        if (r != 8'd0) return hcs_next();
        if (in_time) begin
          ph = PH_CMD58;
          return issue_cmd(CMD_READ_OCR, 32'd0, 1'b0);
        end
        return wrap_up(TYPE_NONE);
      end
      PH_CMD58: begin
        if (r == 8'd0) return read_cond(PH_OCR);
        return wrap_up(TYPE_NONE);
      end
      PH_PROBE: begin
        if (r <= 8'd1) begin
          trial  = TYPE_SDV1;
          legacy = 1'b0;
        end else begin
          trial  = TYPE_MMC;
          legacy = 1'b1;
        end
        el_ms = '0;
        ph = PH_OP_LOOP;
        return op_next();
      end
      PH_OP_LOOP: begin
        if (r != 8'd0) return op_next();
        if (in_time) begin
          ph = PH_CMD16;
          return issue_cmd(CMD_BLOCKLEN, {19'd0, blk_len}, 1'b0);
        end
        return wrap_up(TYPE_NONE);
      end
      PH_CMD16: return wrap_up(r == 8'd0 ? trial : TYPE_NONE);
      default:  return wrap_up(TYPE_NONE);
    endcase
  endfunction

  // An application command answered 0 or 1 goes on to its second half.
  function automatic card_result_t cmd_response(logic [7:0] r);
    resp = r;
    if (app) begin
      if (r > 8'd1) return stage_done(r);
      app = 1'b0;
      return start_link();
    end
    return stage_done(r);
  endfunction

  function automatic logic [7:0] frame_byte(logic [3:0] i);
    logic [5:0]  c;
    logic [31:0] a;
    c = app ? CMD_APP : code;
    a = app ? 32'd0 : arg;
    case (i)
      4'd0: return 8'h40 | {2'b00, c};
      4'd1: return a[31:24];
      4'd2: return a[23:16];
      4'd3: return a[15:8];
      4'd4: return a[7:0];
      default: begin
        if (c == CMD_GO_IDLE) return CRC_CMD0;
        if (c == CMD_IF_COND) return CRC_CMD8;
        return CRC_OTHER;
      end
    endcase
  endfunction

  // Per-command byte steps: deselect, select, ready wait, frame, response poll, and the deselect after a ready timeout.
  function automatic card_result_t link_byte(logic [7:0] rx);
    logic [7:0] b;
    case (lk)
      LK_DESEL: begin
        lk = LK_SEL;
        return mk(8'hFF, 1'b1, 1'b0);
      end
      LK_SEL: begin
        lk = LK_READY;
        rd_ms = '0;
        return mk(8'hFF, 1'b1, 1'b0);
      end
      LK_READY: begin
        if (rx == 8'hFF && rd_ms <= rdy_tmo) begin
          lk = LK_FRAME;
          bidx = 4'd1;
          return mk(frame_byte(4'd0), 1'b1, 1'b0);
        end
        if (rx != 8'hFF && rd_ms < rdy_tmo) return mk(8'hFF, 1'b1, 1'b0);
        lk = LK_FAILDESEL;
        return mk(8'hFF, 1'b0, 1'b0);
      end
      LK_FRAME: begin
        if (bidx < 4'd6) begin
          b = frame_byte(bidx);
          bidx++;
          return mk(b, 1'b1, 1'b0);
        end
        lk = LK_RESP;
        pcnt = 4'd1;
        return mk(8'hFF, 1'b1, 1'b0);
      end
      LK_RESP: begin
        if (rx[7] && pcnt < POLL_BYTES) begin
          pcnt++;
          return mk(8'hFF, 1'b1, 1'b0);
        end
        return cmd_response(rx);
      end
      LK_FAILDESEL: return cmd_response(8'hFF);
      default:      return wrap_up(TYPE_NONE);
    endcase
  endfunction

  // One input transaction; has_res tells whether it yields a result.
  task automatic predict_step(input logic [1:0] op, input logic [7:0] rx,
                              output bit has_res, output card_result_t res);
    has_res = 1'b0;
    res = '0;
    if (op == OP_TICK) begin
      if (el_ms != 16'hFFFF) el_ms++;
      if (rd_ms != 16'hFFFF) rd_ms++;
    end else if (op == OP_START) begin
      ph = PH_WAKE;
      lk = LK_NONE;
      bidx = 4'd1;
      pcnt = '0;
      el_ms = '0;
      rd_ms = '0;
      app = 1'b0;
      cond = '0;
      trial = TYPE_NONE;
      legacy = 1'b0;
      has_res = 1'b1;
      res = mk(8'hFF, 1'b0, 1'b0);
    end else if (op == OP_BYTE && ph != PH_IDLE && ph != PH_DONE) begin
      has_res = 1'b1;
      case (ph)
        PH_WAKE: begin
          if (bidx < DUMMY_BYTES) begin
            bidx++;
            res = mk(8'hFF, 1'b0, 1'b0);
          end else begin
            ph = PH_CMD0;
            res = issue_cmd(CMD_GO_IDLE, 32'd0, 1'b0);
          end
        end
        PH_R7, PH_OCR: begin
          cond = {cond[23:0], rx};
          bidx++;
          if (bidx < 4'd4) res = mk(8'hFF, 1'b1, 1'b0);
          else if (ph == PH_OCR) res = wrap_up(cond[30] ? TYPE_SDHC : TYPE_SDV2);
          else if (cond[15:8] == 8'h01 && cond[7:0] == 8'hAA) begin
            el_ms = '0;
            ph = PH_HCS_LOOP;
            res = hcs_next();
          end else res = wrap_up(TYPE_NONE);
        end
        PH_FINAL: begin
          det = trial;
          uninit = (trial == TYPE_NONE);
          ph = PH_DONE;
          res = mk(8'h00, 1'b0, 1'b1);
        end
        default: res = link_byte(rx);
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit has_res;
    card_result_t res;
    card_result_t got;
    card_result_t want;
    if (!rst_ni) begin
      blk_len = 13'd512;
      rdy_tmo = 16'd500;
      init_tmo = 16'd1000;
      ph = PH_IDLE;
      lk = LK_NONE;
      bidx = '0;
      pcnt = '0;
      el_ms = '0;
      rd_ms = '0;
      code = '0;
      arg = '0;
      app = 1'b0;
      resp = 8'hFF;
      cond = '0;
      trial = TYPE_NONE;
      det = TYPE_NONE;
      uninit = 1'b1;
      legacy = 1'b0;
      expected_results.delete();
      mismatches = 0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // Result side first: a result cannot stem from this edge's input.
      if (out_valid_i && !out_stall_i) begin
        got = '{tx_byte_i, chip_select_low_i, finished_i, card_type_i,
                not_initialized_i};
        if (expected_results.size() == 0) begin
          fail_count_o++;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result tx=%02h cs=%0d fin=%0d type=%0d ninit=%0d",
                     $realtime, got.tx, got.cs, got.fin, got.ctype, got.ninit);
        end else begin
          want = expected_results.pop_front();
          if (got.tx !== want.tx || got.cs !== want.cs || got.fin !== want.fin ||
              got.ctype !== want.ctype || got.ninit !== want.ninit) begin
            fail_count_o++;
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp tx=%02h cs=%0d fin=%0d type=%0d ninit=%0d, got tx=%02h cs=%0d fin=%0d type=%0d ninit=%0d",
                       $realtime, want.tx, want.cs, want.fin, want.ctype, want.ninit,
                       got.tx, got.cs, got.fin, got.ctype, got.ninit);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BLOCK_LENGTH: blk_len = cfg_data_i[12:0];
          CFG_READY_TMO:    rdy_tmo = cfg_data_i;
          CFG_INIT_TMO:     init_tmo = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_step(operation_i, rx_byte_i, has_res, res);
        if (has_res) expected_results.push_back(res);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

### verif/tb_sd_spi_card_init_sequencer_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// SD card SPI init sequencer testbench
// Runs the sequencer against a behavioral card that answers each command by
// card kind (SDHC, SDSC, SDv1, MMC, silent, babbling), with random busy,
// response delay, ticks, restarts and noise, under three idling patterns and
// one long receiver hold-off. The checker beside the block predicts results.
// -----------------------------------------------------------------------------
module tb_sd_spi_card_init_sequencer_top;
  import sdi_pkg::*;

  localparam int ITEM_TARGET = 1800;

  typedef enum int {KIND_SDHC, KIND_SDSC, KIND_SDV1, KIND_MMC, KIND_DEAD,
                    KIND_BABBLE} card_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = OP_NONE;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  tx_byte_o;
  logic        chip_select_low_o;
  logic        finished_o;
  logic [2:0]  card_type_o;
  logic        not_initialized_o;

  int fail_count;
  int pending;

  always #5 clk_i = ~clk_i;

  sd_spi_card_init_sequencer_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .rx_byte_i,
    .out_valid_o, .out_stall_i, .tx_byte_o, .chip_select_low_o,
    .finished_o, .card_type_o, .not_initialized_o
  );

  sd_spi_card_init_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .rx_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .tx_byte_i(tx_byte_o),
    .chip_select_low_i(chip_select_low_o), .finished_i(finished_o),
    .card_type_i(card_type_o), .not_initialized_i(not_initialized_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Idling controls.
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  hold_off = 1'b0;
  event hold_kick;

  // Receiver stall, with a long hold-off stretch on request.
  always @(negedge clk_i)
    out_stall_i <= hold_off || ($urandom_range(0, 99) < rcv_idle_pct);

  initial begin
    forever begin
      @(hold_kick);
      hold_off = 1'b1;
      repeat (300) @(negedge clk_i);
      hold_off = 1'b0;
    end
  end

  // Last accepted result as seen by the card.
  logic [7:0] last_tx = 8'hFF;
  logic       last_cs = 1'b0;
  int         fin_count = 0;
  int         kinds_seen[6];

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      last_tx <= tx_byte_o;
      last_cs <= chip_select_low_o;
      if (finished_o) fin_count <= fin_count + 1;
    end
  end

  int n_items = 0;
  int n_sequences = 0;

  task automatic send_item(input logic [1:0] op, input logic [7:0] rx);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    operation_i = op;
    rx_byte_i = rx;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    n_items++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Behavioral card state.
  card_kind_e kind;
  int         frm_cnt;
  logic [5:0] cur_cmd;
  bit         hcs_bit;
  bit         resp_due;
  int         resp_delay;
  logic [7:0] resp_val;
  logic [7:0] trail[$];
  int         busy_left;
  int         op_busy;
  bit         mmc_no55;

  task automatic card_reset();
    frm_cnt = 0;
    resp_due = 1'b0;
    trail.delete();
    busy_left = 0;
  endtask

  // Response to a complete command frame.
  task automatic card_schedule();
    resp_due = 1'b1;
    resp_delay = ($urandom_range(0, 19) == 0) ? 12 : $urandom_range(0, 2);
    trail.delete();
    case (cur_cmd)
      CMD_GO_IDLE: resp_val = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd1;
      CMD_IF_COND: begin
        if (kind == KIND_SDHC || kind == KIND_SDSC) begin
          resp_val = 8'd1;
          trail = '{8'h00, 8'h00, 8'h01, 8'hAA};
          if ($urandom_range(0, 7) == 0)
            trail[$urandom_range(2, 3)] ^= 8'(1 << $urandom_range(0, 7));
        end else resp_val = 8'h05;
      end
      CMD_APP: resp_val = (kind == KIND_MMC && mmc_no55) ? 8'h05 : 8'd1;
      CMD_APP_OP, CMD_SEND_OP: begin
        if (kind == KIND_MMC && cur_cmd == CMD_APP_OP) resp_val = 8'h05;
        else if (op_busy > 0) begin
          op_busy--;
          resp_val = 8'd1;
        end else resp_val = 8'd0;
      end
      CMD_READ_OCR: begin
        resp_val = ($urandom_range(0, 9) == 0) ? 8'd1 : 8'd0;
        trail = '{(kind == KIND_SDHC) ? 8'hC0 : 8'h80, 8'hFF, 8'h80, 8'h00};
      end
      CMD_BLOCKLEN: resp_val = ($urandom_range(0, 7) == 0) ? 8'h04 : 8'h00;
      default: resp_val = 8'h04;
    endcase
    if (kind == KIND_DEAD) resp_due = 1'b0;
  endtask

  // Byte the card returns while the last result's byte is exchanged.
  task automatic card_answer(output logic [7:0] rx);
    if ($urandom_range(0, 49) == 0 || kind == KIND_BABBLE) begin
      rx = 8'($urandom);
    end else if (frm_cnt > 0) begin
      if (frm_cnt == 1) hcs_bit = last_tx[6];
      frm_cnt++;
      rx = 8'hFF;
      if (frm_cnt == 6) begin
        frm_cnt = 0;
        card_schedule();
      end
    end else if (last_cs && last_tx[7:6] == 2'b01) begin
      cur_cmd = last_tx[5:0];
      frm_cnt = 1;
      resp_due = 1'b0;
      trail.delete();
      rx = 8'hFF;
    end else if (resp_due) begin
      if (resp_delay > 0) begin
        resp_delay--;
        rx = 8'hFF;
      end else begin
        rx = resp_val;
        resp_due = 1'b0;
        busy_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
      end
    end else if (trail.size() != 0) begin
      rx = trail.pop_front();
    end else if (busy_left > 0) begin
      busy_left--;
      rx = 8'h00;
    end else begin
      rx = 8'hFF;
    end
  endtask

  // One bring-up attempt, run in step with the results.
  task automatic run_card_sequence();
    int start_fin;
    int steps;
    int tick_pct;
    logic [7:0] rx;
    kind = card_kind_e'($urandom_range(0, 9) < 8 ? $urandom_range(0, 3)
                                                  : $urandom_range(4, 5));
    kinds_seen[kind]++;
    op_busy = $urandom_range(0, 3);
    mmc_no55 = $urandom_range(0, 1);
    case ($urandom_range(0, 2))
      0: tick_pct = 0;
      1: tick_pct = 5;
      default: tick_pct = 40;
    endcase
    card_reset();
    send_item(OP_START, 8'($urandom));
    wait_drain();
    n_sequences++;
    start_fin = fin_count;
    steps = 0;
    while (fin_count == start_fin && steps < 500) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(OP_TICK, 8'($urandom));
      if ($urandom_range(0, 99) == 0) send_item(OP_NONE, 8'($urandom));
      if ($urandom_range(0, 299) == 0) begin
        // Restart in the middle of a sequence.
        card_reset();
        send_item(OP_START, 8'($urandom));
      end else begin
        card_answer(rx);
        send_item(OP_BYTE, rx);
      end
      wait_drain();
      steps++;
    end
    // Stray bytes after a finished sequence give no result.
    repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom));
    wait_drain();
  endtask

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(2, 6));
      default: return 16'($urandom_range(7, 2000));
    endcase
  endfunction

  function automatic logic [15:0] pick_block_length();
    case ($urandom_range(0, 5))
      0: return 16'd1;
      1: return 16'd4096;
      2: return 16'd0;
      3: return 16'h1FFF;
      default: return 16'($urandom_range(1, 4096));
    endcase
  endfunction

  // Configuration changes happen only once the block has gone quiet.
  task automatic reconfigure();
    wait_drain();
    repeat (4) @(negedge clk_i);
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_BLOCK_LENGTH, pick_block_length());
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_READY_TMO, pick_timeout());
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_INIT_TMO, pick_timeout());
  endtask

  initial begin
    int guard;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: stray items while idle, start, restart, extremes of rx.
    send_item(OP_BYTE, 8'h00);
    send_item(OP_NONE, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_START, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_START, 8'h00);
    repeat (12) send_item(OP_BYTE, 8'hFF);
    send_item(OP_NONE, 8'h55);
    send_item(OP_BYTE, 8'hAA);
    wait_drain();
    repeat (4) @(negedge clk_i);
    cfg_write(CFG_BLOCK_LENGTH, 16'd4096);
    cfg_write(CFG_READY_TMO, 16'd0);
    cfg_write(CFG_INIT_TMO, 16'hFFFF);
    run_card_sequence();
    reconfigure();
    cfg_write(CFG_BLOCK_LENGTH, 16'd1);
    cfg_write(CFG_READY_TMO, 16'hFFFF);
    cfg_write(CFG_INIT_TMO, 16'd1);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin snd_idle_pct = 28; rcv_idle_pct = 65; end
        1: begin snd_idle_pct = 65; rcv_idle_pct = 28; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      if (p == 2) begin
        // Long receiver hold-off while the sender keeps offering items.
        -> hold_kick;
        send_item(OP_START, 8'hFF);
        repeat (60) send_item(OP_BYTE, 8'($urandom));
        wait_drain();
      end
      while (n_items < ITEM_TARGET * (p + 1) / 3) begin
        reconfigure();
        run_card_sequence();
      end
    end

    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending != 0) begin
      $display("Verification failed");
      $finish;
    end
    repeat (5) @(negedge clk_i);
    $display("Ran %0d input transactions over %0d bring-up attempts, %0d completed.",
             n_items, n_sequences, fin_count);
    $display("Cards: %0d SDHC, %0d SDSC, %0d SDv1, %0d MMC, %0d silent, %0d noisy.",
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3],
             kinds_seen[4], kinds_seen[5]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
